// ===== rtl/asm_line_normalizer_assert.svh =====
// Assertion macros for asm_line_normalizer, which checks its own logic.
`ifndef ASM_LINE_NORMALIZER_ASSERT_SVH
`define ASM_LINE_NORMALIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASMLN_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASMLN_IMPLIES_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/asmln_pkg.sv =====
package asmln_pkg;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_Z_LO  = 8'h7A;

	localparam int RES_W = 6;
	localparam logic [RES_W-1:0] RES_LIMIT = 6'd34;
	// The last slot of a step always goes to the closing space.
	localparam logic [RES_W-1:0] RES_KEEP = RES_LIMIT - 6'd1;

	localparam logic REG_IDX_UPCASE = 1'b0;

	typedef struct packed {
		logic comment_cut;
		logic space_pending;
		logic after_comma;
	} filt_state_t;

	typedef struct packed {
		logic       space;
		logic       chr;
		logic [7:0] val;
	} filt_emit_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_last;
		logic       prefix_overflow;
	} res_t;

endpackage

// ===== rtl/asmln_if.sv =====
interface asmln_raw_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       char_present;
	logic       line_end;

	modport source (output valid, output in_char, output char_present, output line_end,
		input ready);
	modport sink (input valid, input in_char, input char_present, input line_end,
		output ready);
endinterface

interface asmln_norm_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       out_last;
	logic       prefix_overflow;

	modport source (output valid, output out_char, output out_last, output prefix_overflow,
		input ready);
	modport sink (input valid, input out_char, input out_last, input prefix_overflow,
		output ready);
endinterface

// ===== rtl/asmln_filter.sv =====
module asmln_filter (
	input  logic [7:0]             byte_val,
	input  asmln_pkg::filt_state_t st,
	output asmln_pkg::filt_state_t st_next,
	output asmln_pkg::filt_emit_t  emit
);
	import asmln_pkg::*;

	logic [7:0] c;

	assign c = (byte_val == CH_TAB) ? CH_SPACE : byte_val;

	always_comb begin
		st_next    = st;
		emit.space = 1'b0;
		emit.chr   = 1'b0;
		emit.val   = c;
		if (st.comment_cut) begin
			st_next = st;
		end else if (c == CH_SEMI) begin
			st_next.comment_cut = 1'b1;
		end else if (c == CH_SPACE) begin
			if (!st.after_comma) begin
				st_next.space_pending = 1'b1;
			end
		end else if (c == CH_COMMA) begin
			st_next.space_pending = 1'b0;
			st_next.after_comma   = 1'b1;
			emit.chr              = 1'b1;
		end else begin
			emit.space            = st.space_pending;
			emit.chr              = 1'b1;
			st_next.space_pending = 1'b0;
			st_next.after_comma   = 1'b0;
		end
	end

endmodule

// ===== rtl/asmln_outq.sv =====
module asmln_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  asmln_pkg::res_t push_data,
	output logic            can_push,
	asmln_norm_if.source    norm
);
	import asmln_pkg::*;

	res_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic [1:0] cnt_n;
	logic       pop;

	assign pop      = norm.valid && norm.ready;
	assign can_push = (cnt_q != 2'd2);

	always_comb begin
		case ({push, pop})
			2'b10:   cnt_n = cnt_q + 2'd1;
			2'b01:   cnt_n = cnt_q - 2'd1;
			default: cnt_n = cnt_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	assign norm.valid           = (cnt_q != 2'd0);
	assign norm.out_char        = ent_q[rd_ptr_q].out_char;
	assign norm.out_last        = ent_q[rd_ptr_q].out_last;
	assign norm.prefix_overflow = ent_q[rd_ptr_q].prefix_overflow;

endmodule

// ===== rtl/asm_line_normalizer.sv =====
// Channel   Direction  Payload                                  Transfer
// raw       in         in_char, char_present, line_end          raw.valid & raw.ready
// norm      out        out_char, out_last, prefix_overflow      norm.valid & norm.ready
// apb       in         upcase_enable at byte address 0          psel & penable & pwrite
//
// An ordinary byte is taken in S_IDLE; a byte releasing a held space adds S_EMIT2.
// A line end after an emitted byte adds S_CLOSE for the closing space.
// A line without letters replays its prefix memory: S_RD reads each stored byte,
// S_RPL filters it, S_EMIT2 follows a released space and S_CLOSE closes the line.
// Reset needs no clearing pass. Results pass a two-entry output queue; raw.ready
// drops while the sequencer is busy or the queue is full.
module asm_line_normalizer #(
	parameter int PREFIX_MAX = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	asmln_raw_if.sink   raw,
	asmln_norm_if.source norm,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import asmln_pkg::*;
	`include "asm_line_normalizer_assert.svh"

	localparam int AW = (PREFIX_MAX > 1) ? $clog2(PREFIX_MAX) : 1;
	localparam int CW = $clog2(PREFIX_MAX + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EMIT2,
		S_RD,
		S_RPL,
		S_CLOSE
	} state_t;

	state_t           state_q, state_n, post_q, post_n, dest;
	logic             upcase_q;
	logic             letter_seen_q, letter_seen_n;
	filt_state_t      filt_q, filt_n;
	logic [CW-1:0]    cnt_q, cnt_n;
	logic             ovf_q, ovf_n;
	logic [CW-1:0]    rd_idx_q, rd_idx_n;
	logic [7:0]       rdata_q;
	logic [7:0]       pend_q, pend_n;
	logic [RES_W-1:0] res_cnt_q, res_cnt_n;
	logic [7:0]       prefix_mem_q [PREFIX_MAX];

	logic        raw_rdy;
	logic        can_push;
	logic        push;
	logic [7:0]  push_char;
	logic        push_last;
	logic        push_ovf;
	res_t        push_data;
	logic        mem_we;
	logic        rd_en;
	logic        line_clr;
	logic        two;
	logic        is_letter;
	logic        more;
	logic [7:0]  filt_byte;
	filt_state_t f_next;
	filt_emit_t  f_emit;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_IDX_UPCASE) ? {31'd0, upcase_q} : 32'd0;

	assign raw_rdy   = (state_q == S_IDLE) && can_push;
	assign raw.ready = raw_rdy;
	assign is_letter = raw.in_char inside {[CH_A_UP:CH_Z_LO]};
	assign more      = (rd_idx_q + CW'(1)) < cnt_q;
	assign filt_byte = (state_q == S_RPL) ? rdata_q : raw.in_char;

	asmln_filter u_filter (
		.byte_val (filt_byte),
		.st       (filt_q),
		.st_next  (f_next),
		.emit     (f_emit)
	);

	always_comb begin
		state_n       = state_q;
		post_n        = post_q;
		dest          = S_IDLE;
		letter_seen_n = letter_seen_q;
		filt_n        = filt_q;
		cnt_n         = cnt_q;
		ovf_n         = ovf_q;
		rd_idx_n      = rd_idx_q;
		pend_n        = pend_q;
		res_cnt_n     = res_cnt_q;
		push          = 1'b0;
		push_char     = CH_SPACE;
		push_last     = 1'b0;
		push_ovf      = ovf_q;
		mem_we        = 1'b0;
		rd_en         = 1'b0;
		line_clr      = 1'b0;
		two           = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (raw.valid && raw_rdy) begin
					res_cnt_n = '0;
					pend_n    = f_emit.val;
					if (raw.char_present) begin
						if (letter_seen_q || is_letter) begin
							letter_seen_n = 1'b1;
							if (!letter_seen_q) begin
								cnt_n = '0;
							end
							filt_n = f_next;
							if (f_emit.space) begin
								push      = 1'b1;
								res_cnt_n = RES_W'(1);
								two       = 1'b1;
							end else if (f_emit.chr) begin
								push      = 1'b1;
								push_char = f_emit.val;
								res_cnt_n = RES_W'(1);
							end
						end else if (cnt_q < CW'(PREFIX_MAX)) begin
							mem_we = 1'b1;
							cnt_n  = cnt_q + CW'(1);
						end else begin
							ovf_n = 1'b1;
						end
					end
					if (!raw.line_end) begin
						dest = S_IDLE;
					end else if (!letter_seen_n && cnt_n != '0) begin
						dest     = S_RD;
						rd_idx_n = '0;
					end else begin
						dest = S_CLOSE;
					end
					if (two) begin
						state_n = S_EMIT2;
						post_n  = dest;
					end else if (dest == S_CLOSE && !push) begin
						push      = 1'b1;
						push_last = 1'b1;
						push_ovf  = ovf_n;
						line_clr  = 1'b1;
						state_n   = S_IDLE;
					end else begin
						state_n = dest;
					end
				end
			end
			S_EMIT2: begin
				if (can_push) begin
					if (res_cnt_q < RES_KEEP) begin
						push      = 1'b1;
						push_char = pend_q;
						res_cnt_n = res_cnt_q + RES_W'(1);
					end
					state_n = post_q;
				end
			end
			S_RD: begin
				rd_en   = 1'b1;
				state_n = S_RPL;
			end
			S_RPL: begin
				if (can_push) begin
					filt_n   = f_next;
					pend_n   = f_emit.val;
					rd_idx_n = rd_idx_q + CW'(1);
					dest     = more ? S_RD : S_CLOSE;
					if (f_emit.space) begin
						if (res_cnt_q < RES_KEEP) begin
							push      = 1'b1;
							res_cnt_n = res_cnt_q + RES_W'(1);
						end
						state_n = S_EMIT2;
						post_n  = dest;
					end else begin
						if (f_emit.chr && res_cnt_q < RES_KEEP) begin
							push      = 1'b1;
							push_char = f_emit.val;
							res_cnt_n = res_cnt_q + RES_W'(1);
						end
						state_n = dest;
					end
				end
			end
			S_CLOSE: begin
				if (can_push) begin
					push      = 1'b1;
					push_last = 1'b1;
					line_clr  = 1'b1;
					state_n   = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
		if (line_clr) begin
			letter_seen_n = 1'b0;
			filt_n        = '0;
			cnt_n         = '0;
			ovf_n         = 1'b0;
		end
	end

	always_comb begin
		push_data.out_last        = push_last;
		push_data.prefix_overflow = push_ovf;
		if (upcase_q && (push_char inside {[CH_A_LO:CH_Z_LO]})) begin
			push_data.out_char = push_char - (CH_A_LO - CH_A_UP);
		end else begin
			push_data.out_char = push_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			post_q        <= S_IDLE;
			upcase_q      <= 1'b1;
			letter_seen_q <= 1'b0;
			filt_q        <= '0;
			cnt_q         <= '0;
			ovf_q         <= 1'b0;
			rd_idx_q      <= '0;
			res_cnt_q     <= '0;
		end else begin
			state_q       <= state_n;
			post_q        <= post_n;
			letter_seen_q <= letter_seen_n;
			filt_q        <= filt_n;
			cnt_q         <= cnt_n;
			ovf_q         <= ovf_n;
			rd_idx_q      <= rd_idx_n;
			res_cnt_q     <= res_cnt_n;
			if (psel && penable && pwrite && paddr[2] == REG_IDX_UPCASE) begin
				upcase_q <= pwdata[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_n;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			prefix_mem_q[cnt_q[AW-1:0]] <= raw.in_char;
		end
		if (rd_en) begin
			rdata_q <= prefix_mem_q[rd_idx_q[AW-1:0]];
		end
	end

	asmln_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.can_push  (can_push),
		.norm      (norm)
	);

	`ASMLN_IMPLIES(a_push_room, clk, arst_n, push, can_push, "Result pushed into a full queue.")
	`ASMLN_IMPLIES(a_rd_in_range, clk, arst_n, state_q == S_RD, rd_idx_q < cnt_q, "Replay read past the stored prefix.")
	`ASMLN_IMPLIES(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(PREFIX_MAX), "Prefix count beyond the memory depth.")
	`ASMLN_IMPLIES_NEXT(a_line_clear, clk, arst_n, push && push_last, cnt_q == '0 && !letter_seen_q && !ovf_q && state_q == S_IDLE, "Line state not cleared after the closing space.")

endmodule

// ===== sim/asmln_checker.sv =====
`timescale 1ns / 1ps

module asmln_checker #(
	parameter int PREFIX_MAX = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	asmln_raw_if        raw,
	asmln_norm_if       norm,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          mismatches,
	output int          pending,
	output int          checked
);
	import asmln_pkg::*;

	localparam logic [2:0] UPCASE_ADDR = {REG_IDX_UPCASE, 2'b00};

	logic       upcase;
	logic       seen;
	logic       cut;
	logic       held_space;
	logic       post_comma;
	logic       ovf;
	logic [7:0] prefix_mem [PREFIX_MAX];
	int         prefix_len;

	res_t norm_want_q[$];
	res_t step_res[$];

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= 100) begin
			$display("ERROR at %0t: %s", $realtime, msg);
		end
	endtask

	task automatic put_char(input logic [7:0] c, input logic last);
		res_t r;
		if (step_res.size() >= int'(RES_LIMIT)) begin
			if (!last) begin
				return;
			end
			step_res.delete(step_res.size() - 1);
		end
		if (upcase && c >= CH_A_LO && c <= CH_Z_LO) begin
			c = c - (CH_A_LO - CH_A_UP);
		end
		r.out_char = c;
		r.out_last = last;
		r.prefix_overflow = ovf;
		step_res.insert(step_res.size(), r);
	endtask

	task automatic filter_byte(input logic [7:0] c);
		if (cut) begin
			return;
		end
		if (c == CH_TAB) begin
			c = CH_SPACE;
		end
		if (c == CH_SEMI) begin
			cut = 1'b1;
			return;
		end
		if (c == CH_SPACE) begin
			if (!post_comma) begin
				held_space = 1'b1;
			end
			return;
		end
		if (c == CH_COMMA) begin
			held_space = 1'b0;
			post_comma = 1'b1;
			put_char(c, 1'b0);
			return;
		end
		if (held_space) begin
			put_char(CH_SPACE, 1'b0);
		end
		held_space = 1'b0;
		post_comma = 1'b0;
		put_char(c, 1'b0);
	endtask

	task automatic predict_line_step(input logic [7:0] c, input logic present, input logic eol);
		step_res.delete();
		if (present) begin
			if (seen) begin
				filter_byte(c);
			end else if (c >= CH_A_UP && c <= CH_Z_LO) begin
				seen = 1'b1;
				prefix_len = 0;
				filter_byte(c);
			end else if (prefix_len < PREFIX_MAX) begin
				prefix_mem[prefix_len] = c;
				prefix_len++;
			end else begin
				ovf = 1'b1;
			end
		end
		if (eol) begin
			if (!seen) begin
				for (int i = 0; i < prefix_len; i++) begin
					filter_byte(prefix_mem[i]);
				end
			end
			put_char(CH_SPACE, 1'b1);
			seen = 1'b0;
			cut = 1'b0;
			held_space = 1'b0;
			post_comma = 1'b0;
			prefix_len = 0;
			ovf = 1'b0;
		end
		foreach (step_res[i]) begin
			norm_want_q.insert(norm_want_q.size(), step_res[i]);
		end
	endtask

	task automatic check_norm(input res_t got);
		res_t want;
		if (norm_want_q.size() == 0) begin
			report($sformatf("unexpected result char=%02h last=%0b ovf=%0b",
				got.out_char, got.out_last, got.prefix_overflow));
			return;
		end
		want = norm_want_q.pop_front();
		if (got.out_char !== want.out_char) begin
			report($sformatf("result %0d out_char got %02h want %02h",
				checked, got.out_char, want.out_char));
		end
		if (got.out_last !== want.out_last) begin
			report($sformatf("result %0d out_last got %0b want %0b",
				checked, got.out_last, want.out_last));
		end
		if (got.prefix_overflow !== want.prefix_overflow) begin
			report($sformatf("result %0d prefix_overflow got %0b want %0b",
				checked, got.prefix_overflow, want.prefix_overflow));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upcase = 1'b1;
			seen = 1'b0;
			cut = 1'b0;
			held_space = 1'b0;
			post_comma = 1'b0;
			ovf = 1'b0;
			prefix_len = 0;
			norm_want_q.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == UPCASE_ADDR) begin
				upcase = pwdata[0];
			end
			if (raw.valid && raw.ready) begin
				predict_line_step(raw.in_char, raw.char_present, raw.line_end);
			end
			if (norm.valid && norm.ready) begin
				check_norm('{norm.out_char, norm.out_last, norm.prefix_overflow});
				checked++;
			end
			pending <= norm_want_q.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import asmln_pkg::*;

	localparam int PREFIX_MAX = 32;
	localparam int IDLE_GAP = 4 * PREFIX_MAX + 40;
	localparam logic [2:0] UPCASE_ADDR = {REG_IDX_UPCASE, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int mismatches;
	int pending;
	int checked;
	int items_sent;
	int lines_sent;
	int burst_left;
	int rx_mode;
	int rx_left;

	logic [7:0] line_q[$];

	asmln_raw_if  raw_ch ();
	asmln_norm_if norm_ch ();

	asm_line_normalizer #(
		.PREFIX_MAX(PREFIX_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.raw(raw_ch),
		.norm(norm_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	asmln_checker #(
		.PREFIX_MAX(PREFIX_MAX)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.raw(raw_ch),
		.norm(norm_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.mismatches(mismatches),
		.pending(pending),
		.checked(checked)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(20, 120);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: norm_ch.ready <= 1'b1;
			1: norm_ch.ready <= ($urandom_range(0, 3) != 0);
			2: norm_ch.ready <= ($urandom_range(0, 3) == 0);
			default: norm_ch.ready <= ((rx_left % 8) < 5);
		endcase
	end

	function automatic logic [7:0] rand_nonletter();
		case ($urandom_range(0, 5))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_COMMA;
			3: return CH_SEMI;
			4: return 8'($urandom_range(0, CH_A_UP - 1));
			default: return 8'($urandom_range(CH_Z_LO + 1, 255));
		endcase
	endfunction

	function automatic logic [7:0] rand_letter();
		return 8'($urandom_range(CH_A_UP, CH_Z_LO));
	endfunction

	function automatic logic [7:0] rand_blank();
		return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
	endfunction

	function automatic logic [7:0] rand_operand_char();
		case ($urandom_range(0, 3))
			0, 1: return rand_letter();
			2: return 8'($urandom_range(8'h30, 8'h39));
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_item(input logic [7:0] c, input logic present, input logic eol);
		raw_ch.valid <= 1'b1;
		raw_ch.in_char <= c;
		raw_ch.char_present <= present;
		raw_ch.line_end <= eol;
		@(posedge clk);
		while (!raw_ch.ready) begin
			@(posedge clk);
		end
		if (present || eol) begin
			items_sent++;
		end
		if (eol) begin
			lines_sent++;
		end
		if (burst_left == 0) begin
			raw_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 60) : $urandom_range(1, 16);
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_text(input string s, input logic close);
		for (int i = 0; i < s.len(); i++) begin
			send_item(s[i], 1'b1, close && i == s.len() - 1);
		end
	endtask

	task automatic append_char(input logic [7:0] c);
		line_q.insert(line_q.size(), c);
	endtask

	task automatic build_line();
		int kind;
		int ops;
		line_q.delete();
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			repeat ($urandom_range(0, 3)) begin
				append_char($urandom_range(0, 1) ? rand_blank() : rand_nonletter());
			end
			repeat ($urandom_range(1, 5)) append_char(rand_letter());
			ops = $urandom_range(0, 3);
			for (int k = 0; k < ops; k++) begin
				if (k > 0) begin
					repeat ($urandom_range(0, 2)) append_char(rand_blank());
					append_char(CH_COMMA);
				end
				repeat ($urandom_range(k == 0 ? 1 : 0, 2)) append_char(rand_blank());
				repeat ($urandom_range(1, 4)) append_char(rand_operand_char());
			end
			repeat ($urandom_range(0, 2)) append_char(rand_blank());
			if ($urandom_range(0, 3) == 0) begin
				append_char(CH_SEMI);
				repeat ($urandom_range(0, 4)) append_char(8'($urandom));
			end
		end else if (kind < 78) begin
			repeat ($urandom_range(0, 12)) append_char(rand_nonletter());
		end else if (kind < 84) begin
			repeat ($urandom_range(PREFIX_MAX - 2, PREFIX_MAX + 6)) begin
				append_char(rand_nonletter());
			end
			if ($urandom_range(0, 1)) begin
				repeat ($urandom_range(1, 4)) append_char(rand_operand_char());
			end
		end else begin
			repeat ($urandom_range(1, 8)) append_char(8'($urandom));
		end
	endtask

	task automatic send_line();
		logic split;
		split = (line_q.size() == 0) || ($urandom_range(0, 9) < 3);
		foreach (line_q[i]) begin
			if ($urandom_range(0, 19) == 0) begin
				send_item(8'($urandom), 1'b0, 1'b0);
			end
			send_item(line_q[i], 1'b1, !split && i == line_q.size() - 1);
		end
		if (split) begin
			send_item(8'($urandom), 1'b0, 1'b1);
		end
	endtask

	task automatic run_random(input int target);
		int start;
		start = items_sent;
		while (items_sent - start < target) begin
			build_line();
			send_line();
		end
	endtask

	task automatic drain();
		raw_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		#2000000;
		$display("Timed out with %0d results outstanding", pending);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		raw_ch.valid = 1'b0;
		raw_ch.in_char = 8'h00;
		raw_ch.char_present = 1'b0;
		raw_ch.line_end = 1'b0;
		norm_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_mode = 0;
		rx_left = 0;
		items_sent = 0;
		lines_sent = 0;
		burst_left = $urandom_range(1, 16);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_write(UPCASE_ADDR, 32'd1);
		send_item(8'h00, 1'b0, 1'b1);
		send_text("  \tmov a ,\tb;x", 1'b1);
		send_text(" 1 ,2", 1'b0);
		send_item(8'hA5, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(CH_Z_LO, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(CH_A_UP - 8'd1, 1'b1, 1'b0);
		send_item(CH_Z_LO + 8'd1, 1'b1, 1'b0);
		send_item(CH_A_UP, 1'b1, 1'b1);
		drain();

		apb_write(UPCASE_ADDR, 32'd0);
		run_random(240);
		drain();

		apb_write(UPCASE_ADDR, 32'hFFFF_FFFF);
		run_random(240);
		drain();

		$display("Checked %0d results from %0d items in %0d lines, case mapping on and off.",
			checked, items_sent, lines_sent);
		$display("Lines held empty, letterless, overlong-prefix, commented and raw-byte content.");
		if (mismatches == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/asmln_pkg.sv
rtl/asmln_if.sv
rtl/asmln_filter.sv
rtl/asmln_outq.sv
rtl/asm_line_normalizer.sv
sim/asmln_checker.sv
sim/tb_top.sv
